// ----- rtl/core/hmu_pkg.sv -----
`default_nettype none
package hmu_pkg;

  // grid geometry
  localparam int ROWS  = 128;
  localparam int COLS  = 128;
  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);      // cell address
  localparam int CW    = $clog2(CELLS + 1);  // running counts

  // serial multiplier: MA_W x MB_W, one multiplier bit per cycle
  localparam int MA_W     = 3 * CW + 4;
  localparam int MB_W     = 24;
  localparam int PW       = MA_W + MB_W;
  localparam int MB_CNT_W = $clog2(MB_W);

  // serial divider: PW-bit dividend, DV_W-bit divisor, one quotient bit per cycle
  localparam int DV_W      = 3 * CW + 1;
  localparam int DIV_CNT_W = $clog2(PW);

  // signed width of d + 2*inner
  localparam int TDW = 2 * CW + 4;

  // 2*N^3, the energy scale
  localparam longint unsigned DEN3 =
    64'd2 * longint'(CELLS) * longint'(CELLS) * longint'(CELLS);

  // exponent path
  localparam int XW = 20;  // x at or above 2^XW always gives a zero threshold
  localparam int YW = 21;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [4:0]  YI_LIMIT  = 5'd17;
  localparam logic [16:0] POW2_TAB [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  localparam int          OV_FRAC = 14;
  localparam logic [14:0] OV_ONE  = 15'd16384;

  localparam logic [15:0] INV_TEMP_RESET = 16'd5120;

  typedef enum logic [1:0] {
    KIND_LOAD_PAT = 2'd0,
    KIND_LOAD_NEU = 2'd1,
    KIND_FLIP     = 2'd2,
    KIND_OVERLAP  = 2'd3
  } hmu_kind_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_OP,
    S_FQN,
    S_FPM,
    S_FT,
    S_FDT_GO,
    S_FDT,
    S_FAK,
    S_FDIV,
    S_FTHR1,
    S_FTHR2,
    S_FAPPLY,
    S_OSTART,
    S_OQN,
    S_OPM,
    S_OPD,
    S_ODIV_GO,
    S_ODIV,
    S_OUT
  } hmu_state_t;

  function automatic logic [16:0] pow2_at(input logic [4:0] k);
    return POW2_TAB[k];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/hopfield_metropolis_update.sv -----
`default_nettype none
// Single-pattern Hopfield grid with Metropolis flips. One beat in gives one beat out.
// Each input beat loads a pattern bit, loads a neuron bit, tries a flip of the addressed
// neuron, or just reads; every result carries the overlap (Q*N - P*M) / (P*(N-P)) in
// Q2.14, rounded and clamped to +-1, with overlap_valid low when the pattern is all
// zeros or all ones. Pattern and neuron bits share one 2-bit-wide RAM. After reset the
// block clears all 16384 cells of that RAM, one cell per cycle, with in_stall high;
// inv_temperature writes are taken at any time but belong in idle periods. Work is
// bit-serial: a shift-add multiplier and a restoring divider are shared by all the
// multiply and divide steps, one item at a time. A load or a read runs three products
// and one divide before out_valid (the divide is skipped when the overlap is invalid);
// a flip attempt first adds three products, and one with a positive energy change
// one more product, one divide and the exp table steps. The next beat is taken as
// soon as the result sits in the output register, even if out_stall holds it there.
module hopfield_metropolis_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [6:0]  in_row,
  input  logic [6:0]  in_col,
  input  logic        in_bit_value,
  input  logic [15:0] in_random_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_neuron,
  output logic        out_flipped,
  output logic signed [15:0] out_overlap,
  output logic        out_overlap_valid
);
  import hmu_pkg::*;

  hmu_state_t state_r, state_nxt;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [15:0]   inv_temp_r;

  // running counts: P pattern ones, M neuron ones, Q shared ones
  logic [CW-1:0] p_ones_r, p_ones_nxt;
  logic [CW-1:0] m_ones_r, m_ones_nxt;
  logic [CW-1:0] q_ones_r, q_ones_nxt;

  // captured beat
  hmu_kind_t     kind_r, kind_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          inside_r, inside_nxt;
  logic          bit_r, bit_nxt;
  logic [15:0]   rnd_r, rnd_nxt;

  // working registers
  logic                  pb_r, pb_nxt;
  logic                  mb_r, mb_nxt;
  logic [2*CW-1:0]       qn_r, qn_nxt;
  logic [2*CW-1:0]       pm_r, pm_nxt;
  logic signed [CW:0]    d_r, d_nxt;
  logic signed [TDW-1:0] t_r, t_nxt;
  logic                  acc_r, acc_nxt;
  logic                  x_big_r, x_big_nxt;
  logic [YW-1:0]         y_r, y_nxt;
  logic [4:0]            yi_r, yi_nxt;
  logic [16:0]           tk_r, tk_nxt;
  logic [23:0]           dw_r, dw_nxt;
  logic [2*CW-1:0]       den_r, den_nxt;
  logic                  num_neg_r, num_neg_nxt;
  logic [2*CW-1:0]       num_mag_r, num_mag_nxt;
  logic                  neu_res_r, neu_res_nxt;
  logic                  flip_res_r, flip_res_nxt;
  logic [15:0]           ov_res_r, ov_res_nxt;
  logic                  ov_val_res_r, ov_val_res_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_neuron_r, out_neuron_nxt;
  logic        out_flipped_r, out_flipped_nxt;
  logic [15:0] out_overlap_r, out_overlap_nxt;
  logic        out_ov_valid_r, out_ov_valid_nxt;

  // address of the incoming beat
  logic          in_inside;
  logic [AW-1:0] in_idx;

  // RAM, {pattern, neuron}
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic [1:0]    ram_rdata;

  // shared units
  logic            mul_start, mul_done;
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [PW-1:0]   mul_prod;
  logic            div_start, div_done;
  logic [PW-1:0]   div_dd;
  logic [DV_W-1:0] div_dv;
  logic [PW-1:0]   div_q;

  // combinational scratch
  logic                  pb, nb;
  logic signed [TDW-1:0] inner, dm;
  logic [TDW-1:0]        t_abs;
  logic [CW:0]           d_abs;
  logic                  e2_pos;
  logic [36:0]           xy;
  logic [3:0]            tab_k;
  logic [16:0]           tab_diff;
  logic [16:0]           v, thr;
  logic                  sat;
  logic [15:0]           ov_mag;
  logic                  out_load;

  assign in_inside = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
  assign in_idx    = in_inside ? AW'(32'(in_row) * COLS + 32'(in_col)) : '0;

  hmu_ram #(
    .WIDTH (2),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  hmu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  hmu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dd),
    .divisor  (div_dv),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    p_ones_nxt     = p_ones_r;
    m_ones_nxt     = m_ones_r;
    q_ones_nxt     = q_ones_r;
    kind_nxt       = kind_r;
    idx_nxt        = idx_r;
    inside_nxt     = inside_r;
    bit_nxt        = bit_r;
    rnd_nxt        = rnd_r;
    pb_nxt         = pb_r;
    mb_nxt         = mb_r;
    qn_nxt         = qn_r;
    pm_nxt         = pm_r;
    d_nxt          = d_r;
    t_nxt          = t_r;
    acc_nxt        = acc_r;
    x_big_nxt      = x_big_r;
    y_nxt          = y_r;
    yi_nxt         = yi_r;
    tk_nxt         = tk_r;
    dw_nxt         = dw_r;
    den_nxt        = den_r;
    num_neg_nxt    = num_neg_r;
    num_mag_nxt    = num_mag_r;
    neu_res_nxt    = neu_res_r;
    flip_res_nxt   = flip_res_r;
    ov_res_nxt     = ov_res_r;
    ov_val_res_nxt = ov_val_res_r;

    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dd    = '0;
    div_dv    = '0;
    out_load  = 1'b0;

    pb       = ram_rdata[1];
    nb       = ram_rdata[0];
    dm       = mb_r ? TDW'(d_r) : '0;
    inner    = $signed({4'b0, qn_r}) - $signed({4'b0, pm_r}) - dm;
    t_abs    = t_r[TDW-1] ? TDW'(-t_r) : TDW'(t_r);
    d_abs    = d_r[CW] ? (CW+1)'(-d_r) : (CW+1)'(d_r);
    e2_pos   = (mul_prod != '0) && ((d_r[CW] ^ t_r[TDW-1]) ^ mb_r);
    xy       = 37'(div_q[XW-1:0]) * 37'(LOG2E_Q16);
    tab_k    = y_r[15:12];
    tab_diff = pow2_at({1'b0, tab_k}) - pow2_at({1'b0, tab_k} + 5'd1);
    v        = tk_r - 17'(dw_r >> 12);
    thr      = (x_big_r || yi_r >= YI_LIMIT) ? '0 : (v >> yi_r);
    sat      = (|div_q[PW-1:15]) || (div_q[14:0] > OV_ONE);
    ov_mag   = sat ? 16'(OV_ONE) : 16'(div_q[14:0]);

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = hmu_kind_t'(in_kind);
          idx_nxt    = in_idx;
          inside_nxt = in_inside;
          bit_nxt    = in_bit_value;
          rnd_nxt    = in_random_fraction;
          state_nxt  = S_OP;
        end
      end
      S_OP: begin
        // RAM data for the captured cell is valid here
        pb_nxt       = pb;
        mb_nxt       = nb;
        neu_res_nxt  = inside_r & nb;
        flip_res_nxt = 1'b0;
        d_nxt        = $signed((CW+1)'(pb ? CELLS : 0)) - $signed({1'b0, p_ones_r});
        state_nxt    = S_OSTART;
        if (inside_r && kind_r == KIND_LOAD_PAT) begin
          if (pb != bit_r) begin
            ram_we     = 1'b1;
            ram_wdata  = {bit_r, nb};
            p_ones_nxt = bit_r ? p_ones_r + 1'b1 : p_ones_r - 1'b1;
            if (nb) begin
              q_ones_nxt = bit_r ? q_ones_r + 1'b1 : q_ones_r - 1'b1;
            end
          end
        end else if (inside_r && kind_r == KIND_LOAD_NEU) begin
          neu_res_nxt = bit_r;
          if (nb != bit_r) begin
            ram_we     = 1'b1;
            ram_wdata  = {pb, bit_r};
            m_ones_nxt = bit_r ? m_ones_r + 1'b1 : m_ones_r - 1'b1;
            if (pb) begin
              q_ones_nxt = bit_r ? q_ones_r + 1'b1 : q_ones_r - 1'b1;
            end
          end
        end else if (inside_r && kind_r == KIND_FLIP) begin
          mul_start = 1'b1;
          mul_a     = MA_W'(CELLS);
          mul_b     = MB_W'(q_ones_r);
          state_nxt = S_FQN;
        end
      end
      S_FQN: begin
        if (mul_done) begin
          qn_nxt    = mul_prod[2*CW-1:0];
          mul_start = 1'b1;
          mul_a     = MA_W'(m_ones_r);
          mul_b     = MB_W'(p_ones_r);
          state_nxt = S_FPM;
        end
      end
      S_FPM: begin
        if (mul_done) begin
          pm_nxt    = mul_prod[2*CW-1:0];
          state_nxt = S_FT;
        end
      end
      S_FT: begin
        t_nxt     = TDW'(d_r) + (inner <<< 1);
        state_nxt = S_FDT_GO;
      end
      S_FDT_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(t_abs);
        mul_b     = MB_W'(d_abs);
        state_nxt = S_FDT;
      end
      S_FDT: begin
        // |d*t| is |E2|; E2 > 0 needs the exp test
        if (mul_done) begin
          if (e2_pos) begin
            mul_start = 1'b1;
            mul_a     = mul_prod[MA_W-1:0];
            mul_b     = {inv_temp_r, 8'b0};
            state_nxt = S_FAK;
          end else begin
            acc_nxt   = 1'b1;
            state_nxt = S_FAPPLY;
          end
        end
      end
      S_FAK: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_dd    = mul_prod;
          div_dv    = DV_W'(DEN3);
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          x_big_nxt = |div_q[PW-1:XW];
          y_nxt     = xy[36:16];
          state_nxt = S_FTHR1;
        end
      end
      S_FTHR1: begin
        yi_nxt    = y_r[20:16];
        tk_nxt    = pow2_at({1'b0, tab_k});
        dw_nxt    = 24'(tab_diff[11:0]) * 24'(y_r[11:0]);
        state_nxt = S_FTHR2;
      end
      S_FTHR2: begin
        acc_nxt   = {1'b0, rnd_r} < thr;
        state_nxt = S_FAPPLY;
      end
      S_FAPPLY: begin
        neu_res_nxt = mb_r;
        if (acc_r) begin
          ram_we       = 1'b1;
          ram_wdata    = {pb_r, ~mb_r};
          neu_res_nxt  = ~mb_r;
          flip_res_nxt = 1'b1;
          m_ones_nxt   = mb_r ? m_ones_r - 1'b1 : m_ones_r + 1'b1;
          if (pb_r) begin
            q_ones_nxt = mb_r ? q_ones_r - 1'b1 : q_ones_r + 1'b1;
          end
        end
        state_nxt = S_OSTART;
      end
      S_OSTART: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(CELLS);
        mul_b     = MB_W'(q_ones_r);
        state_nxt = S_OQN;
      end
      S_OQN: begin
        if (mul_done) begin
          qn_nxt    = mul_prod[2*CW-1:0];
          mul_start = 1'b1;
          mul_a     = MA_W'(m_ones_r);
          mul_b     = MB_W'(p_ones_r);
          state_nxt = S_OPM;
        end
      end
      S_OPM: begin
        if (mul_done) begin
          pm_nxt    = mul_prod[2*CW-1:0];
          mul_start = 1'b1;
          mul_a     = MA_W'(CW'(CELLS) - p_ones_r);
          mul_b     = MB_W'(p_ones_r);
          state_nxt = S_OPD;
        end
      end
      S_OPD: begin
        if (mul_done) begin
          den_nxt     = mul_prod[2*CW-1:0];
          num_neg_nxt = qn_r < pm_r;
          num_mag_nxt = (qn_r < pm_r) ? pm_r - qn_r : qn_r - pm_r;
          state_nxt   = S_ODIV_GO;
        end
      end
      S_ODIV_GO: begin
        if (p_ones_r == '0 || p_ones_r >= CW'(CELLS)) begin
          ov_res_nxt     = '0;
          ov_val_res_nxt = 1'b0;
          state_nxt      = S_OUT;
        end else begin
          // round half away from zero on the magnitude
          div_start = 1'b1;
          div_dd    = (PW'(num_mag_r) << OV_FRAC) + PW'(den_r >> 1);
          div_dv    = DV_W'(den_r);
          state_nxt = S_ODIV;
        end
      end
      S_ODIV: begin
        if (div_done) begin
          ov_res_nxt     = num_neg_r ? 16'(-ov_mag) : ov_mag;
          ov_val_res_nxt = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: holds a beat while out_stall is high
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_neuron_nxt   = out_neuron_r;
    out_flipped_nxt  = out_flipped_r;
    out_overlap_nxt  = out_overlap_r;
    out_ov_valid_nxt = out_ov_valid_r;
    if (out_load) begin
      out_valid_nxt    = 1'b1;
      out_neuron_nxt   = neu_res_r;
      out_flipped_nxt  = flip_res_r;
      out_overlap_nxt  = ov_res_r;
      out_ov_valid_nxt = ov_val_res_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      inv_temp_r  <= INV_TEMP_RESET;
      p_ones_r    <= '0;
      m_ones_r    <= '0;
      q_ones_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      if (cfg_wr_en) begin
        inv_temp_r <= cfg_wr_data;
      end
      p_ones_r    <= p_ones_nxt;
      m_ones_r    <= m_ones_nxt;
      q_ones_r    <= q_ones_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r         <= kind_nxt;
    idx_r          <= idx_nxt;
    inside_r       <= inside_nxt;
    bit_r          <= bit_nxt;
    rnd_r          <= rnd_nxt;
    pb_r           <= pb_nxt;
    mb_r           <= mb_nxt;
    qn_r           <= qn_nxt;
    pm_r           <= pm_nxt;
    d_r            <= d_nxt;
    t_r            <= t_nxt;
    acc_r          <= acc_nxt;
    x_big_r        <= x_big_nxt;
    y_r            <= y_nxt;
    yi_r           <= yi_nxt;
    tk_r           <= tk_nxt;
    dw_r           <= dw_nxt;
    den_r          <= den_nxt;
    num_neg_r      <= num_neg_nxt;
    num_mag_r      <= num_mag_nxt;
    neu_res_r      <= neu_res_nxt;
    flip_res_r     <= flip_res_nxt;
    ov_res_r       <= ov_res_nxt;
    ov_val_res_r   <= ov_val_res_nxt;
    out_neuron_r   <= out_neuron_nxt;
    out_flipped_r  <= out_flipped_nxt;
    out_overlap_r  <= out_overlap_nxt;
    out_ov_valid_r <= out_ov_valid_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_neuron        = out_neuron_r;
  assign out_flipped       = out_flipped_r;
  assign out_overlap       = $signed(out_overlap_r);
  assign out_overlap_valid = out_ov_valid_r;

endmodule
`default_nettype wire

// ----- rtl/core/hmu_ram.sv -----
`default_nettype none
module hmu_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/core/hmu_mul.sv -----
`default_nettype none
module hmu_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [hmu_pkg::MA_W-1:0] a,
  input  logic [hmu_pkg::MB_W-1:0] b,
  output logic                     done,
  output logic [hmu_pkg::PW-1:0]   prod
);
  import hmu_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [MA_W-1:0]     a_r, a_nxt;
  logic [MB_W-1:0]     b_r, b_nxt;
  logic [PW-1:0]       acc_r, acc_nxt;
  logic [MB_CNT_W-1:0] cnt_r, cnt_nxt;

  // MSB-first shift-add, one multiplier bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = (acc_r << 1) + (b_r[MB_W-1] ? PW'(a_r) : '0);
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MB_CNT_W'(MB_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// ----- rtl/core/hmu_div.sv -----
`default_nettype none
module hmu_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [hmu_pkg::PW-1:0]   dividend,
  input  logic [hmu_pkg::DV_W-1:0] divisor,
  output logic                     done,
  output logic [hmu_pkg::PW-1:0]   quotient
);
  import hmu_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [PW-1:0]        dd_r, dd_nxt;   // dividend shifts out, quotient shifts in
  logic [DV_W-1:0]      dv_r, dv_nxt;
  logic [DV_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DV_W:0]        trial;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, dd_r[PW-1]};
    ge       = trial >= {1'b0, dv_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dd_nxt   = dd_r;
    dv_nxt   = dv_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      dd_nxt   = dividend;
      dv_nxt   = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? DV_W'(trial - {1'b0, dv_r}) : DV_W'(trial);
      dd_nxt  = {dd_r[PW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(PW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dd_r  <= dd_nxt;
    dv_r  <= dv_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = dd_r;

endmodule
`default_nettype wire

// ----- rtl/core/hmu_checker.sv -----
`default_nettype none
module hmu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_neuron,
  input logic        out_flipped,
  input logic signed [15:0] out_overlap,
  input logic        out_overlap_valid
);

  // an invalid overlap always reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overlap_valid |-> out_overlap == 16'sd0)
    else $error("overlap nonzero while flagged invalid");

  // overlap clamped to +-1.0 in Q2.14
  a_overlap_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overlap <= 16'sd16384) && (out_overlap >= -16'sd16384))
    else $error("overlap out of range");

  // one beat in flight: the block is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken without work");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_overlap) && $stable(out_neuron)
      && $stable(out_flipped) && $stable(out_overlap_valid))
    else $error("stalled result beat changed");

endmodule

bind hopfield_metropolis_update hmu_checker u_hmu_checker (.*);
`default_nettype wire
